FILE: rtl/core/oal_pkg.sv
package oal_pkg;

    // List geometry.
    localparam int CAPACITY  = 16;
    localparam int ELEM_BITS = 32;

    // Field widths of the stream items.
    localparam int KIND_BITS   = 2;
    localparam int POS_BITS    = 5;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int FPOS_BITS   = 5;
    localparam int COUNT_BITS  = 5;

    // Internal widths derived from the capacity.
    localparam int IDX_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS + 1 : POS_BITS + 1;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_RAW_BITS  = POS_BITS + VALUE_BITS;
    localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS = STATUS_BITS + 1 + FPOS_BITS + VALUE_BITS + COUNT_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int USER_BITS    = 8;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_FIND   = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What one cell does at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TAKE_LEFT  = 2'd1,
        CELL_TAKE_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     in_range;
    } cell_ctl_t;

    // Result item, last field in the lowest bits once packed.
    typedef struct packed {
        logic                   is_empty;
        logic [COUNT_BITS-1:0]  count;
        logic [VALUE_BITS-1:0]  read_value;
        logic [FPOS_BITS-1:0]   found_position;
        logic                   found;
        status_t                status;
    } result_t;

endpackage

FILE: rtl/core/oal_cell.sv
module oal_cell (
    input  logic                       clk,
    input  oal_pkg::cell_ctl_t         ctl,
    input  logic [oal_pkg::ELEM_BITS-1:0] key,
    input  logic [oal_pkg::ELEM_BITS-1:0] left,
    input  logic [oal_pkg::ELEM_BITS-1:0] right,
    output logic [oal_pkg::ELEM_BITS-1:0] data,
    output logic                       match
);
    import oal_pkg::*;

    logic [ELEM_BITS-1:0] data_reg;
    logic [ELEM_BITS-1:0] data_next;

    // The entry holds no reset value; it is only seen once it has been written.
    always_comb
    begin
        unique case (ctl.op)
            CELL_HOLD:       data_next = data_reg;
            CELL_TAKE_LEFT:  data_next = left;
            CELL_TAKE_RIGHT: data_next = right;
            CELL_LOAD:       data_next = key;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = ctl.in_range && (data_reg == key);

endmodule

FILE: rtl/core/ordered_array_list.sv
// Channel | Direction | Signals                    | Contents
// --------+-----------+----------------------------+---------------------------------------
// request | in        | s_tvalid s_tready s_tdata  | one list operation; kind in s_tuser
//         |           | s_tuser                    |
// result  | out       | m_tvalid m_tready m_tdata  | status, match, read entry and count
//
// Each request is handled in a single pass: the row of cells shifts, compares and
// loads in parallel, and the result is offered in the cycle after the transfer.
// A new request is taken in every cycle while the result register is empty or
// is being drained, so the sustained rate is one item per clock.
// rst_n clears the element count and the result valid flag; the entries keep
// whatever they hold and are only observed once written.
// A stalled result holds the request side off until it has been taken.
module ordered_array_list (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Bits [4:0] position, [36:5] value, [39:37] zero.
    input  logic [oal_pkg::IN_DATA_BITS-1:0]  s_tdata,
    // Bits [1:0] kind, [7:2] zero.
    input  logic [oal_pkg::USER_BITS-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Bits [1:0] status, [2] found, [7:3] found_position, [39:8] read_value,
    // [44:40] count, [45] is_empty, [47:46] zero.
    output logic [oal_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import oal_pkg::*;

    // Request fields.
    kind_t                 kind;
    logic [POS_BITS-1:0]   position;
    logic [VALUE_BITS-1:0] value;
    logic [ELEM_BITS-1:0]  key;
    logic                  accept;

    assign kind     = kind_t'(s_tuser[KIND_BITS-1:0]);
    assign position = s_tdata[POS_BITS-1:0];
    assign value    = s_tdata[POS_BITS +: VALUE_BITS];
    assign key      = value[ELEM_BITS-1:0];

    // Control state.
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             result_reg;
    result_t             result_next;

    // Position and count compared at a common width, so that a position far
    // beyond the capacity is never mistaken for a small one.
    logic [CMP_BITS-1:0] pos_w;
    logic [CMP_BITS-1:0] cnt_w;

    assign pos_w = CMP_BITS'(position);
    assign cnt_w = CMP_BITS'(count_reg);

    logic ins_range_err;
    logic ins_full;
    logic ins_ok;
    logic era_ok;
    logic rd_ok;

    assign ins_range_err = (pos_w > cnt_w);
    assign ins_full      = (cnt_w == CMP_BITS'(CAPACITY));
    assign ins_ok        = accept && (kind == KIND_INSERT) && !ins_range_err && !ins_full;
    assign era_ok        = accept && (kind == KIND_ERASE) && (pos_w < cnt_w);
    assign rd_ok         = (pos_w < cnt_w);

    // The row of cells. Each cell sees its neighbours on both sides: an insert
    // moves entries one place up from the insert position, an erase moves them
    // one place down onto the erased slot.
    cell_ctl_t            ctl   [CAPACITY];
    logic [ELEM_BITS-1:0] cdata [CAPACITY];
    logic [CAPACITY-1:0]  match;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            localparam logic [CMP_BITS-1:0] IDX = CMP_BITS'(g);
            logic [ELEM_BITS-1:0] left_data;
            logic [ELEM_BITS-1:0] right_data;

            if (g == 0)
            begin : g_first
                assign left_data = '0;
            end
            else
            begin : g_inner_left
                assign left_data = cdata[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_data = '0;
            end
            else
            begin : g_inner_right
                assign right_data = cdata[g+1];
            end

            always_comb
            begin
                ctl[g].in_range = (IDX < cnt_w);
                priority if (ins_ok && (IDX == pos_w))
                    ctl[g].op = CELL_LOAD;
                else if (ins_ok && (IDX > pos_w) && (IDX <= cnt_w))
                    ctl[g].op = CELL_TAKE_LEFT;
                else if (era_ok && (IDX >= pos_w) && ((IDX + 1'b1) < cnt_w))
                    ctl[g].op = CELL_TAKE_RIGHT;
                else
                    ctl[g].op = CELL_HOLD;
            end

            oal_cell u_cell (
                .clk   (clk),
                .ctl   (ctl[g]),
                .key   (key),
                .left  (left_data),
                .right (right_data),
                .data  (cdata[g]),
                .match (match[g])
            );
        end
    endgenerate

    // First match wins: scan from the top so the lowest index is left standing.
    logic                hit;
    logic [IDX_BITS-1:0] hit_idx;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit     = 1'b1;
                hit_idx = IDX_BITS'(i);
            end
        end
    end

    // Result and count update.
    always_comb
    begin
        count_next  = count_reg;
        result_next = result_reg;
        if (accept)
        begin
            result_next.status         = ST_OK;
            result_next.found          = 1'b0;
            result_next.found_position = '0;
            result_next.read_value     = '0;
            unique case (kind)
                KIND_INSERT:
                begin
                    if (ins_range_err)
                        result_next.status = ST_RANGE;
                    else if (ins_full)
                        result_next.status = ST_FULL;
                    else
                        count_next = count_reg + 1'b1;
                end
                KIND_ERASE:
                begin
                    if (era_ok)
                        count_next = count_reg - 1'b1;
                    else
                        result_next.status = ST_RANGE;
                end
                KIND_FIND:
                begin
                    result_next.found = hit;
                    if (hit)
                        result_next.found_position = FPOS_BITS'(hit_idx) + 1'b1;
                end
                KIND_READ:
                begin
                    if (rd_ok)
                        result_next.read_value =
                            VALUE_BITS'(cdata[position[IDX_BITS-1:0]]);
                    else
                        result_next.status = ST_RANGE;
                end
                default:
                begin
                    result_next.status = ST_OK;
                end
            endcase
            result_next.count    = COUNT_BITS'(count_next);
            result_next.is_empty = (count_next == '0);
        end
    end

    // Output register: a new request may enter while the held result is taken.
    assign s_tready       = !out_valid_reg || m_tready;
    assign accept         = s_tvalid && s_tready;
    assign out_valid_next = accept || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(result_reg);

endmodule

FILE: rtl/core/oal_checker.sv
module oal_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [oal_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import oal_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata[OUT_RAW_BITS-1:0]);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // The empty flag follows the count.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.is_empty == (res.count == '0)))
        else $error("empty flag disagrees with count");

    // A match carries a position within the list, and no match carries none.
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res.found ? (res.found_position != '0 &&
                                   res.found_position <= res.count)
                                : (res.found_position == '0)))
        else $error("found position inconsistent");

    // A full rejection is reported only with the list at capacity.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (res.status == ST_FULL) |-> (res.count == COUNT_BITS'(CAPACITY)))
        else $error("full status with spare room");

    // Each accepted request yields a result at the next edge.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

endmodule

bind ordered_array_list oal_checker u_oal_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: test/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import oal_pkg::*;

    // Cycles without a single transfer on either channel before the run is abandoned.
    localparam int QUIET_LIMIT = 1000;
    localparam int USER_PAD    = USER_BITS - KIND_BITS;
    localparam int DATA_PAD    = IN_DATA_BITS - IN_RAW_BITS;

    // Shadow of the list. It works out the result of every accepted request
    // and keeps the results that are still owed by the block, oldest first.
    class list_tracker;
        logic [ELEM_BITS-1:0] cells [CAPACITY];
        int unsigned          fill;
        result_t              awaited_results [$];
        int unsigned          failures;
        int unsigned          kind_tally [4];
        int unsigned          range_hits;
        int unsigned          full_hits;
        int unsigned          find_hits;
        int unsigned          peak;

        function void note_request(kind_t kind, logic [POS_BITS-1:0] pos,
                                   logic [VALUE_BITS-1:0] value);
            result_t r;
            int      p;
            int      n;
            r        = '0;
            r.status = ST_OK;
            p        = int'(pos);
            n        = int'(fill);
            kind_tally[kind]++;
            if (kind == KIND_INSERT)
            begin
                if (p > n)
                    r.status = ST_RANGE;
                else if (n >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = n; i > p; i--)
                        cells[IDX_BITS'(i)] = cells[IDX_BITS'(i - 1)];
                    cells[IDX_BITS'(p)] = value[ELEM_BITS-1:0];
                    fill++;
                end
            end
            else if (kind == KIND_ERASE)
            begin
                if (p >= n)
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < n; i++)
                        cells[IDX_BITS'(i)] = cells[IDX_BITS'(i + 1)];
                    fill--;
                end
            end
            else if (kind == KIND_FIND)
            begin
                // Only the first match counts.
                for (int i = 0; i < n; i++)
                    if (!r.found && cells[IDX_BITS'(i)] == value[ELEM_BITS-1:0])
                    begin
                        r.found          = 1'b1;
                        r.found_position = FPOS_BITS'(i + 1);
                    end
                if (r.found)
                    find_hits++;
            end
            else
            begin
                if (p >= n)
                    r.status = ST_RANGE;
                else
                    r.read_value = cells[IDX_BITS'(p)];
            end
            if (r.status == ST_RANGE)
                range_hits++;
            if (r.status == ST_FULL)
                full_hits++;
            if (fill > peak)
                peak = fill;
            r.count    = COUNT_BITS'(fill);
            r.is_empty = (fill == 0);
            awaited_results.push_back(r);
        endfunction

        function void check_field(string name, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("Mismatch in %s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("Result transfer arrived with no request outstanding");
                failures++;
                return;
            end
            want = awaited_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("found", want.found, got.found);
            check_field("found_position", want.found_position, got.found_position);
            check_field("read_value", want.read_value, got.read_value);
            check_field("count", want.count, got.count);
            check_field("is_empty", want.is_empty, got.is_empty);
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    logic [USER_BITS-1:0]     s_tuser  = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;

    // Set for the closing stretch, where neither side idles.
    bit                       calm = 1'b0;
    list_tracker              sb = new();

    ordered_array_list u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Presents one request and holds it until the block takes it. The valid
    // flag is left high so that a following request can run on without a gap.
    task automatic send_request(kind_t kind, logic [POS_BITS-1:0] pos,
                                logic [VALUE_BITS-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= {{USER_PAD{1'b0}}, kind};
        s_tdata  <= {{DATA_PAD{1'b0}}, value, pos};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, pos, value);
    endtask

    task automatic maybe_idle(int pct);
        if (!calm && $urandom_range(0, 99) < pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Holds the request side off until the block has delivered every result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Values for inserts: mostly random, with a small pool that makes
    // duplicates likely and the signed extremes now and then.
    function automatic logic [VALUE_BITS-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return $urandom;
        if (roll < 85)
            return VALUE_BITS'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // One phase of random traffic. The weights steer the list towards growth,
    // shrinkage or churn; most positions are legal for the current fill, so
    // the list really moves, and the rest are anywhere in the field's range.
    task automatic run_phase(int items, int w_ins, int w_era, int w_find, int w_read,
                             int idle_pct);
        int          roll;
        kind_t       kind;
        logic [4:0]  pos;
        logic [31:0] value;
        for (int n = 0; n < items; n++)
        begin
            roll = $urandom_range(0, w_ins + w_era + w_find + w_read - 1);
            if (roll < w_ins)
                kind = KIND_INSERT;
            else if (roll < w_ins + w_era)
                kind = KIND_ERASE;
            else if (roll < w_ins + w_era + w_find)
                kind = KIND_FIND;
            else
                kind = KIND_READ;

            if ($urandom_range(0, 99) < 15)
                pos = POS_BITS'($urandom_range(0, 31));
            else if (kind == KIND_INSERT)
                pos = POS_BITS'($urandom_range(0, sb.fill));
            else if (sb.fill > 0)
                pos = POS_BITS'($urandom_range(0, sb.fill - 1));
            else
                pos = POS_BITS'($urandom_range(0, 31));

            if (kind == KIND_INSERT)
                value = pick_value();
            else if (kind == KIND_FIND && sb.fill > 0 && $urandom_range(0, 9) < 6)
                value = sb.cells[IDX_BITS'($urandom_range(0, sb.fill - 1))];
            else if (kind == KIND_FIND)
                value = pick_value();
            else
                value = $urandom;

            send_request(kind, pos, value);
            maybe_idle(idle_pct);
        end
    endtask

    // Result side: stalls in bursts between ready stretches of varying length,
    // and stays ready once the run turns calm.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(40, 120)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Every result transfer is checked against the oldest outstanding prediction.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(result_t'(m_tdata[OUT_RAW_BITS-1:0]));
        end
    end

    // Watchdog: a long run of cycles with no transfer at all means the block hung.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the empty list, the edges of the position range,
        // front, middle and end inserts, the signed extremes, then a fill to
        // capacity and the rejections that only a full list can give.
        send_request(KIND_READ, 5'd0, 32'h0000_0000);
        send_request(KIND_ERASE, 5'd0, 32'h0000_0000);
        send_request(KIND_FIND, 5'd0, 32'h0000_0000);
        send_request(KIND_INSERT, 5'd1, 32'h1111_1111);
        send_request(KIND_INSERT, 5'd0, 32'h7FFF_FFFF);
        maybe_idle(50);
        send_request(KIND_INSERT, 5'd1, 32'h8000_0000);
        send_request(KIND_INSERT, 5'd0, 32'h0000_0000);
        send_request(KIND_INSERT, 5'd1, 32'hFFFF_FFFF);
        send_request(KIND_FIND, 5'd31, 32'h8000_0000);
        send_request(KIND_FIND, 5'd0, 32'h1234_5678);
        maybe_idle(50);
        send_request(KIND_READ, 5'd31, 32'hFFFF_FFFF);
        send_request(KIND_READ, 5'd3, 32'h0000_0000);
        send_request(KIND_READ, 5'd4, 32'h0000_0000);
        send_request(KIND_ERASE, 5'd4, 32'h0000_0000);
        send_request(KIND_ERASE, 5'd0, 32'h0000_0000);
        send_request(KIND_ERASE, 5'd2, 32'h0000_0000);
        // A duplicate of the head entry lands part-way through the fill, so
        // a later find must still report the first match.
        while (sb.fill < CAPACITY - 1)
        begin
            send_request(KIND_INSERT, POS_BITS'(sb.fill),
                         (sb.fill == 5) ? 32'hFFFF_FFFF : 32'h5A5A_0000 + sb.fill);
            maybe_idle(25);
        end
        send_request(KIND_INSERT, POS_BITS'(sb.fill), 32'hDEAD_BEEF);
        send_request(KIND_INSERT, 5'd16, 32'h0BAD_F00D);
        send_request(KIND_INSERT, 5'd0, 32'h0BAD_F00D);
        send_request(KIND_INSERT, 5'd20, 32'h0BAD_F00D);
        send_request(KIND_FIND, 5'd0, 32'hFFFF_FFFF);
        send_request(KIND_FIND, 5'd0, 32'hDEAD_BEEF);
        send_request(KIND_READ, 5'd15, 32'h0000_0000);
        drain_results();

        // Random part, in phases of different character.
        run_phase(60, 2, 6, 2, 2, 30);
        run_phase(70, 6, 1, 2, 2, 30);
        run_phase(60, 4, 1, 2, 2, 0);
        drain_results();
        run_phase(70, 1, 6, 2, 2, 40);
        run_phase(110, 3, 3, 2, 2, 20);
        drain_results();
        run_phase(60, 6, 1, 2, 2, 10);
        run_phase(30, 1, 5, 2, 2, 30);

        // Closing stretch with both sides running flat out.
        calm = 1'b1;
        run_phase(80, 3, 3, 2, 2, 0);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Covered %0d requests: %0d inserts, %0d erases, %0d finds, %0d reads.",
                 sb.kind_tally[KIND_INSERT] + sb.kind_tally[KIND_ERASE] +
                 sb.kind_tally[KIND_FIND] + sb.kind_tally[KIND_READ],
                 sb.kind_tally[KIND_INSERT], sb.kind_tally[KIND_ERASE],
                 sb.kind_tally[KIND_FIND], sb.kind_tally[KIND_READ]);
        $display("Out-of-range rejections %0d, full-list rejections %0d,",
                 sb.range_hits, sb.full_hits);
        $display("finds that hit %0d, peak fill %0d.", sb.find_hits, sb.peak);
        if (sb.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
